// ----- rtl/core/stunp_pkg.sv -----
package stunp_pkg;

	// Header layout and byte counter limits
	localparam logic [16:0] HDR_BYTES  = 17'd20;
	localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

	// Fixed masks from the protocol
	localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
	localparam logic [15:0] PORT_MASK    = 16'h2112;
	localparam logic [7:0]  FAM_IPV4     = 8'h01;

	// Attribute types that are understood
	localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
	localparam logic [15:0] ATTR_PRIORITY    = 16'h0024;
	localparam logic [15:0] ATTR_USE_CAND    = 16'h0025;
	localparam logic [15:0] ATTR_CONTROLLED  = 16'h8029;
	localparam logic [15:0] ATTR_CONTROLLING = 16'h802A;

	// Smallest attribute length that can hold an IPv4 mapped address
	localparam logic [15:0] XMA_MIN_LEN = 16'd8;

	// Result error codes, lowest nonzero wins
	localparam logic [2:0] ERR_OK     = 3'd0;
	localparam logic [2:0] ERR_SHORT  = 3'd1;
	localparam logic [2:0] ERR_COOKIE = 3'd2;
	localparam logic [2:0] ERR_LENGTH = 3'd3;
	localparam logic [2:0] ERR_ATTR   = 3'd4;

	// ICE flag bit positions
	localparam int ICE_CONTROLLING = 0;
	localparam int ICE_CONTROLLED  = 1;
	localparam int ICE_USE_CAND    = 2;

	// Attribute walk state and captured results
	typedef struct packed {
		logic [13:0] skip_words;   // value words left in current attribute
		logic        xma;          // current attribute is a usable XOR-MAPPED-ADDRESS
		logic [1:0]  val_idx;      // value words seen, saturates at 2
		logic [15:0] pend_port;    // unmasked port waiting for the address word
		logic        fam_ok;       // IPv4 family seen in current attribute
		logic        pend_prio;    // next walked word is the priority value
		logic [31:0] addr;
		logic [15:0] port;
		logic        has_addr;
		logic [31:0] prio;
		logic        has_prio;
		logic [2:0]  ice;
		logic [2:0]  sticky_err;
	} attr_st_t;

endpackage

// ----- rtl/core/stunp_attr_walk.sv -----
module stunp_attr_walk (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    clear,
	input  logic                    walk,
	input  logic [31:0]             word,
	output stunp_pkg::attr_st_t     st_nxt
);

	stunp_pkg::attr_st_t st_q;

	// Walk one body word: attribute header or value word
	always_comb begin
		st_nxt = st_q;
		if (walk && st_q.sticky_err == stunp_pkg::ERR_OK) begin
			// take the priority value from the word after a PRIORITY header
			if (st_q.pend_prio) begin
				st_nxt.prio      = word;
				st_nxt.pend_prio = 1'b0;
			end
			if (st_q.skip_words != 14'd0) begin
				if (st_q.xma) begin
					if (st_q.val_idx == 2'd0) begin
						st_nxt.pend_port = word[15:0] ^ stunp_pkg::PORT_MASK;
						st_nxt.fam_ok    = (word[23:16] == stunp_pkg::FAM_IPV4);
					end else if (st_q.val_idx == 2'd1 && st_q.fam_ok &&
							st_q.pend_port != 16'd0) begin
						st_nxt.addr     = word ^ stunp_pkg::MAGIC_COOKIE;
						st_nxt.port     = st_q.pend_port;
						st_nxt.has_addr = 1'b1;
					end
				end
				st_nxt.skip_words = st_q.skip_words - 14'd1;
				if (st_q.val_idx != 2'd2) begin
					st_nxt.val_idx = st_q.val_idx + 2'd1;
				end
			end else begin
				// decode a new attribute header
				st_nxt.xma     = 1'b0;
				st_nxt.val_idx = 2'd0;
				st_nxt.fam_ok  = 1'b0;
				unique case (word[31:16])
					stunp_pkg::ATTR_XOR_MAPPED: begin
						st_nxt.xma = (word[15:0] >= stunp_pkg::XMA_MIN_LEN);
					end
					stunp_pkg::ATTR_CONTROLLING: begin
						st_nxt.ice[stunp_pkg::ICE_CONTROLLING] = 1'b1;
					end
					stunp_pkg::ATTR_CONTROLLED: begin
						st_nxt.ice[stunp_pkg::ICE_CONTROLLED] = 1'b1;
					end
					stunp_pkg::ATTR_USE_CAND: begin
						st_nxt.ice[stunp_pkg::ICE_USE_CAND] = 1'b1;
					end
					stunp_pkg::ATTR_PRIORITY: begin
						st_nxt.prio      = 32'd0;
						st_nxt.has_prio  = 1'b1;
						st_nxt.pend_prio = 1'b1;
					end
					default: begin
						st_nxt.sticky_err = stunp_pkg::ERR_ATTR;
					end
				endcase
				st_nxt.skip_words = word[15:2];
			end
		end
	end

	// Advance on every item, drop everything at the end of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			if (clear) begin
				st_q <= '0;
			end else begin
				st_q <= st_nxt;
			end
		end
	end

endmodule

// ----- rtl/core/stun_message_parser_unit.sv -----
// STUN message parser. Takes a received packet one byte per item, with last_byte set on the
// final byte, and gives one result item per packet: header type and length, transaction ID,
// the IPv4 XOR-MAPPED-ADDRESS, PRIORITY and the ICE flags, with an error code (too short, bad
// cookie, length mismatch, unknown attribute; the lowest applies). A new byte is accepted in
// every cycle while no result is held back: each byte updates the header registers or the
// attribute walker in a single pass, and the result lands in an output register in the cycle
// after the last byte. While a result waits in that register and is not taken, the input is
// held off for every byte, so the next packet flows only once the result is taken; a result
// taken in the same cycle as an input byte costs no stall.
module stun_message_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  error_code,
	output logic [15:0] message_type,
	output logic [15:0] body_length,
	output logic [31:0] txid_high,
	output logic [63:0] txid_low,
	output logic [31:0] mapped_address,
	output logic [15:0] mapped_port,
	output logic        has_mapped_address,
	output logic [31:0] priority_value,
	output logic        has_priority,
	output logic [2:0]  ice_flags
);

	logic [16:0] byte_count_q, byte_count_nxt;
	logic [15:0] header_type_q, header_type_nxt;
	logic [15:0] header_length_q, header_length_nxt;
	logic [31:0] cookie_q, cookie_nxt;
	logic [31:0] txid_upper_q, txid_upper_nxt;
	logic [63:0] txid_lower_q, txid_lower_nxt;
	logic [31:0] word_q, word_nxt;

	logic        accept;
	logic        advance;
	logic [16:0] off;
	logic        walk;
	logic        hdr_ok, ids_ok, attrs_ok;
	logic [2:0]  err;

	stunp_pkg::attr_st_t st_nxt;

	logic        out_valid_q;
	logic [2:0]  error_code_q;
	logic [15:0] message_type_q;
	logic [15:0] body_length_q;
	logic [31:0] txid_high_q;
	logic [63:0] txid_low_q;
	logic [31:0] mapped_address_q;
	logic [15:0] mapped_port_q;
	logic        has_mapped_address_q;
	logic [31:0] priority_value_q;
	logic        has_priority_q;
	logic [2:0]  ice_flags_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign advance  = (byte_count_q != stunp_pkg::COUNT_MAX);
	assign off      = byte_count_q - stunp_pkg::HDR_BYTES;

	// Place the byte in the header field or the body word
	always_comb begin
		byte_count_nxt    = byte_count_q;
		header_type_nxt   = header_type_q;
		header_length_nxt = header_length_q;
		cookie_nxt        = cookie_q;
		txid_upper_nxt    = txid_upper_q;
		txid_lower_nxt    = txid_lower_q;
		word_nxt          = word_q;
		walk              = 1'b0;
		if (advance) begin
			byte_count_nxt = byte_count_q + 17'd1;
			if (byte_count_q < 17'd2) begin
				header_type_nxt = {header_type_q[7:0], data_byte};
			end else if (byte_count_q < 17'd4) begin
				header_length_nxt = {header_length_q[7:0], data_byte};
			end else if (byte_count_q < 17'd8) begin
				cookie_nxt = {cookie_q[23:0], data_byte};
			end else if (byte_count_q < 17'd12) begin
				txid_upper_nxt = {txid_upper_q[23:0], data_byte};
			end else if (byte_count_q < stunp_pkg::HDR_BYTES) begin
				txid_lower_nxt = {txid_lower_q[55:0], data_byte};
			end else begin
				word_nxt = {word_q[23:0], data_byte};
				walk = (off[1:0] == 2'd3) && ({2'b00, off[16:2]} < {3'b000, header_length_q[15:2]})
					&& (cookie_q == stunp_pkg::MAGIC_COOKIE);
			end
		end
	end

	stunp_attr_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.clear  (last_byte),
		.walk   (walk),
		.word   (word_nxt),
		.st_nxt (st_nxt)
	);

	// Pick the error code and which field groups are reported
	always_comb begin
		hdr_ok   = 1'b1;
		ids_ok   = 1'b1;
		attrs_ok = 1'b1;
		if (byte_count_nxt < stunp_pkg::HDR_BYTES) begin
			err      = stunp_pkg::ERR_SHORT;
			hdr_ok   = 1'b0;
			ids_ok   = 1'b0;
			attrs_ok = 1'b0;
		end else if (cookie_nxt != stunp_pkg::MAGIC_COOKIE) begin
			err      = stunp_pkg::ERR_COOKIE;
			ids_ok   = 1'b0;
			attrs_ok = 1'b0;
		end else if (byte_count_nxt != ({1'b0, header_length_nxt} + stunp_pkg::HDR_BYTES)) begin
			err      = stunp_pkg::ERR_LENGTH;
			attrs_ok = 1'b0;
		end else begin
			err = st_nxt.sticky_err;
		end
	end

	// Hold packet state, drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_type_q   <= '0;
			header_length_q <= '0;
			cookie_q        <= '0;
			txid_upper_q    <= '0;
			txid_lower_q    <= '0;
			word_q          <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_count_q    <= '0;
				header_type_q   <= '0;
				header_length_q <= '0;
				cookie_q        <= '0;
				txid_upper_q    <= '0;
				txid_lower_q    <= '0;
				word_q          <= '0;
			end else begin
				byte_count_q    <= byte_count_nxt;
				header_type_q   <= header_type_nxt;
				header_length_q <= header_length_nxt;
				cookie_q        <= cookie_nxt;
				txid_upper_q    <= txid_upper_nxt;
				txid_lower_q    <= txid_lower_nxt;
				word_q          <= word_nxt;
			end
		end
	end

	// Result item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result item at the last byte
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			error_code_q         <= err;
			message_type_q       <= hdr_ok ? header_type_nxt : 16'd0;
			body_length_q        <= hdr_ok ? header_length_nxt : 16'd0;
			txid_high_q          <= ids_ok ? txid_upper_nxt : 32'd0;
			txid_low_q           <= ids_ok ? txid_lower_nxt : 64'd0;
			mapped_address_q     <= attrs_ok ? st_nxt.addr : 32'd0;
			mapped_port_q        <= attrs_ok ? st_nxt.port : 16'd0;
			has_mapped_address_q <= attrs_ok && st_nxt.has_addr;
			priority_value_q     <= attrs_ok ? st_nxt.prio : 32'd0;
			has_priority_q       <= attrs_ok && st_nxt.has_prio;
			ice_flags_q          <= attrs_ok ? st_nxt.ice : 3'd0;
		end
	end

	assign out_valid          = out_valid_q;
	assign error_code         = error_code_q;
	assign message_type       = message_type_q;
	assign body_length        = body_length_q;
	assign txid_high          = txid_high_q;
	assign txid_low           = txid_low_q;
	assign mapped_address     = mapped_address_q;
	assign mapped_port        = mapped_port_q;
	assign has_mapped_address = has_mapped_address_q;
	assign priority_value     = priority_value_q;
	assign has_priority       = has_priority_q;
	assign ice_flags          = ice_flags_q;

endmodule
